/* src/mno_pkg.sv */
// Shared types, constants and lookup tables for the mono note oscillator.
// Depends on nothing; every other file imports it.
package mno_pkg;

  localparam int PHASE_BITS       = 24;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SAMPLE_BITS      = 16;

  localparam int CMD_BITS      = 2;
  localparam int NOTE_BITS     = 7;
  localparam int OFFSET_BITS   = 9;
  localparam int VOLUME_BITS   = 16;
  localparam int REF_BITS      = 23;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  localparam int MANT_COUNT    = 192;
  localparam int MANT_BITS     = 17;
  localparam int MANT_IDX_BITS = $clog2(MANT_COUNT);
  localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_BITS     = REF_BITS + MANT_BITS;
  localparam int SHIFT_BITS    = 5;
  localparam int EXP_BITS      = 12;

  // Biased exponent: note*16 + offset - 1104 + 1536, always positive.
  localparam int EXP_BIAS        = 432;
  // Right shift applied to the product is 24 minus the octave index.
  localparam int OCT_BASE        = 24;
  // Octave index = (exponent / 64) / 3, done as a multiply by 43 and shift by 7.
  localparam int OCT_RECIP       = 43;
  localparam int OCT_RECIP_SHIFT = 7;
  localparam int OCT_BITS        = 4;

  localparam logic [PROD_BITS-1:0] STEP_LIMIT =
    PROD_BITS'((64'd1 << (PHASE_BITS - 1)) - 64'd1);

  localparam logic [63:0] MANT_MULT_Q30 = 64'd1077625178;
  localparam logic [63:0] PI_Q30        = 64'd3373259426;
  localparam logic [63:0] SINE_AMP      = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [63:0] SINE_DIV      = 64'(4 * SINE_TABLE_DEPTH);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SINE     = 2'd3
  } wave_t;

  typedef enum logic [2:0] {
    REG_OSC_ENABLE    = 3'd0,
    REG_WAVEFORM      = 3'd1,
    REG_PITCH_OFFSET  = 3'd2,
    REG_VOLUME        = 3'd3,
    REG_REF_INCREMENT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_PHASE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                          osc_enable;
    wave_t                         waveform;
    logic signed [OFFSET_BITS-1:0] pitch_offset;
    logic [VOLUME_BITS-1:0]        volume;
    logic [REF_BITS-1:0]           ref_increment;
  } cfg_t;

  // Commands from the controller to the datapath; at most one is high.
  typedef struct packed {
    logic load_exp;
    logic note_on;
    logic note_off;
    logic mul;
    logic phase;
    logic out_load;
  } dp_cmd_t;

  typedef logic [MANT_BITS-1:0]     mant_rom_t [MANT_COUNT];
  typedef logic [SAMPLE_BITS-2:0]   sine_rom_t [SINE_TABLE_DEPTH];

  // Entry k is 2^(k/192) in Q1.16, built by repeated Q30 multiplication.
  function automatic mant_rom_t build_mant_rom();
    mant_rom_t   rom;
    logic [63:0] m;
    int          k;
    m = 64'd1 << 30;
    for (k = 0; k < MANT_COUNT; k++) begin
      rom[k] = MANT_BITS'((m + (64'd1 << 13)) >> 14);
      m = (m * MANT_MULT_Q30 + (64'd1 << 29)) >> 30;
    end
    return rom;
  endfunction

  // Quarter sine wave sampled at bin centers, Taylor series in Q30.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    int          i;
    for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x    = (64'(2 * i + 1) * PI_Q30) / SINE_DIV;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = (sum > term) ? sum - term : 64'd0;
      if (sum > (64'd1 << 30)) begin
        sum = 64'd1 << 30;
      end
      rom[i] = (SAMPLE_BITS-1)'((sum * SINE_AMP + (64'd1 << 29)) >> 30);
    end
    return rom;
  endfunction

  localparam mant_rom_t MANT_ROM = build_mant_rom();
  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* src/mno_if.sv */
// Handshake channel interfaces for note commands in and samples out.
// Depends on mno_pkg for field widths.
interface mno_in_if;
  import mno_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  command;
  logic [NOTE_BITS-1:0] note_number;

  modport source (output valid, output command, output note_number, input ready);
  modport sink   (input valid, input command, input note_number, output ready);
endinterface

interface mno_out_if;
  import mno_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* src/mno_cfg.sv */
// APB-style configuration registers of the oscillator.
// Depends on mno_pkg for the register map and the cfg_t struct.
module mno_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mno_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [mno_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [mno_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready,
  output mno_pkg::cfg_t                       cfg
);
  import mno_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_OSC_ENABLE:    cfg_nxt.osc_enable    = cfg_pwdata[0];
        REG_WAVEFORM:      cfg_nxt.waveform      = wave_t'(cfg_pwdata[1:0]);
        REG_PITCH_OFFSET:  cfg_nxt.pitch_offset  = signed'(cfg_pwdata[OFFSET_BITS-1:0]);
        REG_VOLUME:        cfg_nxt.volume        = cfg_pwdata[VOLUME_BITS-1:0];
        REG_REF_INCREMENT: cfg_nxt.ref_increment = cfg_pwdata[REF_BITS-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OSC_ENABLE:    cfg_prdata = CFG_DATA_BITS'(cfg_r.osc_enable);
      REG_WAVEFORM:      cfg_prdata = CFG_DATA_BITS'(cfg_r.waveform);
      REG_PITCH_OFFSET:  cfg_prdata = CFG_DATA_BITS'(unsigned'(cfg_r.pitch_offset));
      REG_VOLUME:        cfg_prdata = CFG_DATA_BITS'(cfg_r.volume);
      REG_REF_INCREMENT: cfg_prdata = CFG_DATA_BITS'(cfg_r.ref_increment);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.osc_enable    <= 1'b1;
      cfg_r.waveform      <= WAVE_SAW;
      cfg_r.pitch_offset  <= '0;
      cfg_r.volume        <= VOLUME_BITS'(32768);
      cfg_r.ref_increment <= REF_BITS'(153791);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/mno_ctrl.sv */
// Controller state machine: accepts words, sequences the datapath and
// owns the result valid flag. Depends on mno_pkg.
module mno_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [mno_pkg::CMD_BITS-1:0]   in_command,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mno_pkg::dp_cmd_t               dp_cmd
);
  import mno_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   in_fire;
  logic   out_free;
  cmd_t   cmd;

  assign cmd       = cmd_t'(in_command);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && cmd == CMD_TICK) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_PHASE;
      ST_PHASE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    dp_cmd   = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cmd)
            CMD_TICK:     dp_cmd.load_exp = 1'b1;
            CMD_NOTE_ON:  dp_cmd.note_on  = 1'b1;
            CMD_NOTE_OFF: dp_cmd.note_off = 1'b1;
            default:      dp_cmd = '0;
          endcase
        end
      end
      ST_MUL:   dp_cmd.mul   = 1'b1;
      ST_PHASE: dp_cmd.phase = 1'b1;
      ST_OUT:   dp_cmd.out_load = out_free;
      default:  dp_cmd = '0;
    endcase
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A held result must never be overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !dp_cmd.out_load)
    else $error("result register overwritten while stalled");

  // An accepted tick reaches the output state through the multiply and phase states.
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == CMD_TICK) |=> ##2 (state_r == ST_OUT))
    else $error("tick did not reach the output state in time");

  // Loading a result always raises valid on the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |=> out_valid_r)
    else $error("result loaded without valid");

  // The datapath gets at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(dp_cmd))
    else $error("more than one datapath command");

endmodule

/* src/mno_dpath.sv */
// Oscillator datapath: note state, step computation, phase accumulator,
// waveform shaping and volume scaling. Depends on mno_pkg and its ROMs.
module mno_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mno_pkg::dp_cmd_t                      dp_cmd,
  input  mno_pkg::cfg_t                         cfg,
  input  logic [mno_pkg::NOTE_BITS-1:0]         note_number,
  output logic signed [mno_pkg::SAMPLE_BITS-1:0] sample
);
  import mno_pkg::*;

  localparam int TRI_BITS = SAMPLE_BITS + 2;
  localparam int P_BITS   = SAMPLE_BITS + VOLUME_BITS + 1;

  localparam logic signed [TRI_BITS-1:0] TRI_F   =
    TRI_BITS'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic signed [TRI_BITS-1:0] TRI_F3  = TRI_F + TRI_F + TRI_F;
  localparam logic signed [TRI_BITS-1:0] TRI_MAX = TRI_F - TRI_BITS'(1);

  logic [NOTE_BITS-1:0]          held_note_r;
  logic                          gate_r;
  logic [PHASE_BITS-1:0]         phase_r;
  logic [MANT_BITS-1:0]          mant_r;
  logic [SHIFT_BITS-1:0]         shift_r;
  logic [PROD_BITS-1:0]          prod_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  // Exponent split into octave and mantissa index.
  logic [EXP_BITS-1:0]              ee;
  logic [10:0]                      oct_prod;
  logic [OCT_BITS-1:0]              oct;
  logic [EXP_BITS-1:0]              frac_full;
  logic [MANT_IDX_BITS-1:0]         frac;
  logic [SHIFT_BITS-1:0]            shift_nxt;

  always_comb begin
    ee        = {1'b0, held_note_r, 4'b0000} + EXP_BITS'(cfg.pitch_offset)
                + EXP_BITS'(EXP_BIAS);
    oct_prod  = 11'(ee[EXP_BITS-1:6]) * 11'(OCT_RECIP);
    oct       = oct_prod[10:OCT_RECIP_SHIFT];
    frac_full = ee - EXP_BITS'(oct) * EXP_BITS'(MANT_COUNT);
    frac      = frac_full[MANT_IDX_BITS-1:0];
    shift_nxt = SHIFT_BITS'(OCT_BASE) - SHIFT_BITS'(oct);
  end

  // Step saturation and phase advance.
  logic [PROD_BITS-1:0]  shifted;
  logic [PROD_BITS-1:0]  step_sat;
  logic [PHASE_BITS-1:0] phase_nxt;

  always_comb begin
    shifted   = prod_r >> shift_r;
    step_sat  = (shifted > STEP_LIMIT) ? STEP_LIMIT : shifted;
    phase_nxt = phase_r + step_sat[PHASE_BITS-1:0];
  end

  // Waveform shaping and gain.
  logic [PHASE_BITS+SAMPLE_BITS-1:0] ph_ext;
  logic [SAMPLE_BITS-1:0]            u;
  logic signed [TRI_BITS-1:0]        uu;
  logic signed [TRI_BITS-1:0]        tri_v;
  logic [1:0]                        quad;
  logic [SINE_IDX_BITS-1:0]          sidx;
  logic signed [SAMPLE_BITS-1:0]     sv;
  logic signed [SAMPLE_BITS-1:0]     y;
  logic signed [P_BITS-1:0]          p;
  logic signed [SAMPLE_BITS-1:0]     scaled;

  always_comb begin
    ph_ext = {phase_r, {SAMPLE_BITS{1'b0}}} >> PHASE_BITS;
    u      = ph_ext[SAMPLE_BITS-1:0];
    uu     = signed'({2'b00, u});
    if (!u[SAMPLE_BITS-1]) begin
      tri_v = (uu <<< 1) - TRI_F;
    end else begin
      tri_v = TRI_F3 - (uu <<< 1);
    end
    if (tri_v > TRI_MAX) begin
      tri_v = TRI_MAX;
    end
    quad = phase_r[PHASE_BITS-1:PHASE_BITS-2];
    sidx = phase_r[PHASE_BITS-3 -: SINE_IDX_BITS];
    if (quad[0]) begin
      sidx = ~sidx;
    end
    sv = signed'({1'b0, SINE_ROM[sidx]});
    if (quad[1]) begin
      sv = -sv;
    end
    case (cfg.waveform)
      WAVE_SAW:      y = signed'({~u[SAMPLE_BITS-1], u[SAMPLE_BITS-2:0]});
      WAVE_SQUARE:   y = u[SAMPLE_BITS-1] ? signed'({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                                          : signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
      WAVE_TRIANGLE: y = tri_v[SAMPLE_BITS-1:0];
      WAVE_SINE:     y = sv;
      default:       y = '0;
    endcase
    p      = y * signed'({1'b0, cfg.volume});
    scaled = p[SAMPLE_BITS+VOLUME_BITS-1:VOLUME_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_note_r <= '0;
      gate_r      <= 1'b0;
      phase_r     <= '0;
    end else begin
      if (dp_cmd.note_on) begin
        held_note_r <= note_number;
        gate_r      <= 1'b1;
      end
      if (dp_cmd.note_off && note_number == held_note_r) begin
        gate_r <= 1'b0;
      end
      if (dp_cmd.phase) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_exp) begin
      mant_r  <= MANT_ROM[frac];
      shift_r <= shift_nxt;
    end
    if (dp_cmd.mul) begin
      prod_r <= PROD_BITS'(cfg.ref_increment) * PROD_BITS'(mant_r);
    end
    if (dp_cmd.out_load) begin
      sample_r <= (cfg.osc_enable && gate_r) ? scaled : '0;
    end
  end

  assign sample = sample_r;

endmodule

/* src/mono_note_oscillator_core.sv */
// Top level of the monophonic note oscillator.
// Depends on mno_pkg, mno_if, mno_cfg, mno_ctrl and mno_dpath.
//
//   channel   dir   handshake            words carried
//   in_ch     in    valid/ready          command, note_number
//   out_ch    out   valid/ready          sample (signed Q1.15)
//   cfg_*     in    APB psel/penable     osc_enable, waveform, pitch_offset,
//                                        volume, ref_increment
//
// On acceptance a sample tick looks up the pitch mantissa, then the controller
// steps through the 23x17 step multiply, the phase update and the waveform
// and gain stage; no new word is accepted until the tick has left them.
// Note on and note off words, and the unused command, are accepted in idle and
// give no result. Reset (rst_n low, synchronous) clears the phase, closes
// the gate and loads the register defaults. A stalled result waits in the
// output register; the next word is still accepted, and only a tick that
// reaches its last stage behind a stalled result waits there.
module mono_note_oscillator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  mno_in_if.sink                            in_ch,
  mno_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mno_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [mno_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [mno_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import mno_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dp_cmd;
  logic    in_ready;
  logic    out_valid;
  logic signed [SAMPLE_BITS-1:0] sample;

  // Register file; the user must write only while the oscillator is idle, which the block does not enforce.
  mno_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The controller decodes the command word and steps the datapath
  // through multiply, phase and output stages.
  mno_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .dp_cmd     (dp_cmd)
  );

  // The datapath holds the note, gate and phase and forms the sample.
  mno_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .cfg         (cfg),
    .note_number (in_ch.note_number),
    .sample      (sample)
  );

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.sample = sample;

endmodule
